// ===== design/rcsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcsfd_pkg
// Shared types and constants of the radio-receiver serial frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsfd_pkg;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] REG_TICK_LIMIT   = 2'd0;
  localparam logic [1:0] REG_LOST_LIMIT   = 2'd1;
  localparam logic [1:0] REG_THROTTLE_MIN = 2'd2;

  localparam logic [3:0]  TICK_LIMIT_RST   = 4'd4;
  localparam logic [5:0]  LOST_LIMIT_RST   = 6'd30;
  localparam logic [10:0] THROTTLE_MIN_RST = 11'd10;

  localparam logic [7:0] SYNC_NARROW_A = 8'h01;
  localparam logic [7:0] SYNC_NARROW_B = 8'hB2;
  localparam logic [7:0] SYNC_NARROW_C = 8'h02;
  localparam logic [7:0] SYNC_WIDE     = 8'h12;
  localparam logic [7:0] PREV_BYTE_RST = 8'hFF;

  localparam logic [4:0] SYNC_POS  = 5'd2;
  localparam logic [4:0] FRAME_LEN = 5'd16;

  typedef struct packed {
    logic [3:0]  tick_limit;
    logic [5:0]  lost_limit;
    logic [10:0] throttle_min;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic run_req;
    logic cnt_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/rc_satellite_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// rc_satellite_frame_decoder
// Decodes 16-byte radio-receiver frames into runs of channel values.
// ----------------------------------------------------------------------------
// Input channel: one item per transfer, either a received byte (mode_i = 0)
// or a supervisor tick (mode_i = 1). Output channel: one channel per
// transfer; a run carries CHANNELS results in index order, last_o on the
// final one, signal_lost_o on a zeroed run after too many resyncs.
// Each input item is taken while the controller is idle. An item that closes
// a good frame or declares signal lost starts a run: in_stall_o then stays
// high while the run moves through the single output register, one channel
// per cycle while the output is not stalled. The first result is loaded from
// the EMIT state entered on the accepting edge, once the output is free.
// A stall on the output holds the current result and pauses the run; the
// input is stalled until the last channel of the run is loaded.
// Reset clears the frame state, counters and all staged channels and
// loads the register defaults (tick_limit 4, lost_limit 30, throttle_min 10).
// Registers sit at byte addresses 0, 4 and 8 of the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_satellite_frame_decoder #(
  parameter int unsigned CHANNELS = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         mode_i,
  input  wire logic [7:0]                   data_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [3:0]                        channel_index_o,
  output logic [10:0]                       channel_value_o,
  output logic                              signal_lost_o,
  output logic                              last_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rcsfd_pkg::APB_AW-1:0] paddr,
  input  wire logic [rcsfd_pkg::APB_DW-1:0] pwdata,
  output logic      [rcsfd_pkg::APB_DW-1:0] prdata,
  output logic                              pready
);

  rcsfd_pkg::cfg_t       cfg;
  rcsfd_pkg::ctl_cmd_t   cmd;
  rcsfd_pkg::dp_status_t status;

  rcsfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rcsfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rcsfd_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .mode_i          (mode_i),
    .data_byte_i     (data_byte_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .signal_lost_o   (signal_lost_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// ===== design/rcsfd_cfg.sv =====
// ----------------------------------------------------------------------------
// rcsfd_cfg
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfd_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rcsfd_pkg::APB_AW-1:0] paddr,
  input  wire logic [rcsfd_pkg::APB_DW-1:0] pwdata,
  output logic      [rcsfd_pkg::APB_DW-1:0] prdata,
  output logic                              pready,
  output rcsfd_pkg::cfg_t                   cfg_o
);

  rcsfd_pkg::cfg_t cfg_q;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_limit   <= rcsfd_pkg::TICK_LIMIT_RST;
      cfg_q.lost_limit   <= rcsfd_pkg::LOST_LIMIT_RST;
      cfg_q.throttle_min <= rcsfd_pkg::THROTTLE_MIN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        rcsfd_pkg::REG_TICK_LIMIT:   cfg_q.tick_limit   <= pwdata[3:0];
        rcsfd_pkg::REG_LOST_LIMIT:   cfg_q.lost_limit   <= pwdata[5:0];
        rcsfd_pkg::REG_THROTTLE_MIN: cfg_q.throttle_min <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      rcsfd_pkg::REG_TICK_LIMIT:   prdata[3:0]  = cfg_q.tick_limit;
      rcsfd_pkg::REG_LOST_LIMIT:   prdata[5:0]  = cfg_q.lost_limit;
      rcsfd_pkg::REG_THROTTLE_MIN: prdata[10:0] = cfg_q.throttle_min;
      default:                     prdata       = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/rcsfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcsfd_ctrl
// Controller: takes items while idle and drains a channel run one per cycle while the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfd_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  rcsfd_pkg::dp_status_t      status_i,
  output rcsfd_pkg::ctl_cmd_t        cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   stall_q;

  assign in_stall_o = stall_q;

  always_comb begin
    cmd_o.accept = in_valid_i && (state_q == ST_IDLE);
    cmd_o.load   = (state_q == ST_EMIT) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.accept && status_i.run_req) begin
            state_q <= ST_EMIT;
            stall_q <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (cmd_o.load && status_i.cnt_last) begin
            state_q <= ST_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/rcsfd_dpath.sv =====
// ----------------------------------------------------------------------------
// rcsfd_dpath
// Datapath: frame tracking, channel staging, supervision counters and the
// output register of the channel run.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfd_dpath #(
  parameter int unsigned CHANNELS = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  rcsfd_pkg::cfg_t       cfg_i,
  input  rcsfd_pkg::ctl_cmd_t   cmd_i,
  output rcsfd_pkg::dp_status_t status_o,
  input  wire logic             mode_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output logic [3:0]            channel_index_o,
  output logic [10:0]           channel_value_o,
  output logic                  signal_lost_o,
  output logic                  last_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic        in_sync_q, in_sync_d;
  logic [4:0]  pos_q, pos_d;
  logic [7:0]  prev_q, prev_d;
  logic        wide_q, wide_d;
  logic        bad_q, bad_d;
  logic [3:0]  tick_q, tick_d;
  logic [5:0]  sil_q, sil_d;
  logic        lost_q, lost_d;
  logic [3:0]  cnt_q;
  logic        out_valid_q;
  logic [3:0]  out_idx_q;
  logic [10:0] out_val_q;
  logic        out_lost_q;
  logic        out_last_q;
  logic [10:0] stage_q [CHANNELS];

  logic [4:0]  pos_inc;
  logic [15:0] word;
  logic [3:0]  id;
  logic [10:0] val;
  logic        bad_eff;
  logic        stage_we;
  logic        stage_clr;
  logic        run_req;
  logic [4:0]  tick_inc;
  logic [6:0]  sil_inc;
  logic        cnt_last;

  assign cnt_last = (cnt_q == 4'(CHANNELS - 1));

  always_comb begin
    in_sync_d = in_sync_q;
    pos_d     = pos_q;
    prev_d    = prev_q;
    wide_d    = wide_q;
    bad_d     = bad_q;
    tick_d    = tick_q;
    sil_d     = sil_q;
    lost_d    = 1'b0;
    stage_we  = 1'b0;
    stage_clr = 1'b0;
    run_req   = 1'b0;
    pos_inc   = pos_q + 5'd1;
    word      = {prev_q, data_byte_i};
    id        = wide_q ? word[14:11] : word[13:10];
    val       = wide_q ? word[10:0] : {1'b0, word[9:0]};
    bad_eff   = bad_q;
    tick_inc  = {1'b0, tick_q} + 5'd1;
    sil_inc   = {1'b0, sil_q} + 7'd1;
    if (mode_i) begin
      if (tick_inc > {1'b0, cfg_i.tick_limit}) begin
        in_sync_d = 1'b0;
        pos_d     = '0;
        prev_d    = rcsfd_pkg::PREV_BYTE_RST;
        bad_d     = 1'b0;
        tick_d    = '0;
        if (sil_inc > {1'b0, cfg_i.lost_limit}) begin
          sil_d     = '0;
          stage_clr = 1'b1;
          run_req   = 1'b1;
          lost_d    = 1'b1;
        end else begin
          sil_d = sil_inc[5:0];
        end
      end else begin
        tick_d = tick_inc[3:0];
      end
    end else begin
      pos_d  = pos_inc;
      prev_d = data_byte_i;
      if (!in_sync_q) begin
        if (pos_inc == rcsfd_pkg::SYNC_POS) begin
          if (data_byte_i == rcsfd_pkg::SYNC_NARROW_A ||
              data_byte_i == rcsfd_pkg::SYNC_NARROW_B ||
              data_byte_i == rcsfd_pkg::SYNC_NARROW_C) begin
            wide_d    = 1'b0;
            in_sync_d = 1'b1;
          end else if (data_byte_i == rcsfd_pkg::SYNC_WIDE) begin
            wide_d    = 1'b1;
            in_sync_d = 1'b1;
          end else begin
            pos_d = '0;
          end
        end
      end else if (!pos_inc[0]) begin
        if (id == 4'd0 && val < cfg_i.throttle_min) begin
          bad_eff = 1'b1;
        end
        stage_we = ({1'b0, id} < 5'(CHANNELS)) && !bad_eff;
      end
      bad_d = bad_eff;
      if (pos_inc == rcsfd_pkg::FRAME_LEN) begin
        pos_d     = '0;
        in_sync_d = 1'b0;
        sil_d     = '0;
        run_req   = !bad_eff;
        bad_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sync_q <= 1'b0;
      pos_q     <= '0;
      prev_q    <= rcsfd_pkg::PREV_BYTE_RST;
      wide_q    <= 1'b0;
      bad_q     <= 1'b0;
      tick_q    <= '0;
      sil_q     <= '0;
      lost_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.accept) begin
        in_sync_q <= in_sync_d;
        pos_q     <= pos_d;
        prev_q    <= prev_d;
        wide_q    <= wide_d;
        bad_q     <= bad_d;
        tick_q    <= tick_d;
        sil_q     <= sil_d;
        lost_q    <= lost_d;
        cnt_q     <= '0;
      end else if (cmd_i.load) begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        stage_q[i] <= '0;
      end
    end else if (cmd_i.accept) begin
      if (stage_clr) begin
        for (int i = 0; i < CHANNELS; i++) begin
          stage_q[i] <= '0;
        end
      end else if (stage_we) begin
        stage_q[id[IdxW-1:0]] <= val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_idx_q  <= cnt_q;
      out_val_q  <= stage_q[cnt_q[IdxW-1:0]];
      out_lost_q <= lost_q;
      out_last_q <= cnt_last;
    end
  end

  assign status_o.run_req  = run_req;
  assign status_o.cnt_last = cnt_last;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign channel_index_o = out_idx_q;
  assign channel_value_o = out_val_q;
  assign signal_lost_o   = out_lost_q;
  assign last_o          = out_last_q;

endmodule

`default_nettype wire

// ===== design/rcsfd_checker.sv =====
// ----------------------------------------------------------------------------
// rcsfd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfd_checker #(
  parameter int unsigned CHANNELS = 12
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [3:0]  channel_index_o,
  input wire logic [10:0] channel_value_o,
  input wire logic        signal_lost_o,
  input wire logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(channel_index_o) &&
      $stable(channel_value_o) && $stable(signal_lost_o) && $stable(last_o))
    else $error("stalled output changed");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> channel_index_o == 4'(CHANNELS - 1))
    else $error("last flag on wrong channel");

  a_lost_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && signal_lost_o |-> channel_value_o == 11'd0)
    else $error("signal lost run carries nonzero value");

  a_run_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken during a run");

endmodule

bind rc_satellite_frame_decoder rcsfd_checker #(
  .CHANNELS (CHANNELS)
) u_rcsfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .channel_index_o (channel_index_o),
  .channel_value_o (channel_value_o),
  .signal_lost_o   (signal_lost_o),
  .last_o          (last_o)
);

`default_nettype wire

// ===== tb/sv/rc_satellite_frame_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// rc_satellite_frame_decoder_tb
// Self-checking testbench for the radio-receiver serial frame decoder.
// A short stimulus table covers sync handling, word extremes, an out of
// range channel id and a signal-lost run. Random phases then feed mostly
// well-formed frames mixed with ticks, noise and cut frames under several
// register settings. A predictor tracks the frame state and queues the
// channel results that every accepted transfer causes; each output transfer
// is compared field by field against the oldest queued result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rc_satellite_frame_decoder_tb;

  localparam int CHANNELS    = 12;
  localparam int STUCK_LIMIT = 2000;
  localparam int SETTLE      = 4;
  localparam int PHASE_ITEMS = 12;
  localparam int STORM_TICKS = 48;

  typedef struct packed {
    logic [3:0]  index;
    logic [10:0] value;
    logic        lost;
    logic        last;
  } chan_res_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_TICK, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_LOST} row_chk_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [10:0] value;
    row_chk_e    chk;
  } dir_row_t;

  localparam int DIR_ROWS = 21;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic                          mode_i      = 1'b0;
  logic [7:0]                    data_byte_i = 8'h00;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [3:0]                    channel_index_o;
  logic [10:0]                   channel_value_o;
  logic                          signal_lost_o;
  logic                          last_o;
  logic                          psel        = 1'b0;
  logic                          penable     = 1'b0;
  logic                          pwrite      = 1'b0;
  logic [rcsfd_pkg::APB_AW-1:0]  paddr       = '0;
  logic [rcsfd_pkg::APB_DW-1:0]  pwdata      = '0;
  logic [rcsfd_pkg::APB_DW-1:0]  prdata;
  logic                          pready;

  rc_satellite_frame_decoder #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .data_byte_i,
    .out_valid_o,
    .out_stall_i,
    .channel_index_o,
    .channel_value_o,
    .signal_lost_o,
    .last_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rcsfd_pkg::cfg_t cfg = '{rcsfd_pkg::TICK_LIMIT_RST, rcsfd_pkg::LOST_LIMIT_RST,
                           rcsfd_pkg::THROTTLE_MIN_RST};
  logic        fr_sync   = 1'b0;
  logic [4:0]  fr_pos    = '0;
  logic [7:0]  fr_prev   = rcsfd_pkg::PREV_BYTE_RST;
  logic        fr_wide   = 1'b0;
  logic        fr_bad    = 1'b0;
  logic [10:0] stage_val [CHANNELS];
  logic [3:0]  tick_cnt  = '0;
  logic [5:0]  resync_cnt = '0;

  chan_res_t   pending_chans [$];
  int          errors      = 0;
  int          items_sent  = 0;
  int          last_made   = 0;
  logic        last_lost   = 1'b0;
  bit          quiet       = 1'b0;
  int          stuck_cycles = 0;

  initial begin
    foreach (stage_val[i]) stage_val[i] = '0;
  end

  function automatic int push_run(input logic lost);
    chan_res_t r;
    for (int i = 0; i < CHANNELS; i++) begin
      r.index = 4'(i);
      r.value = stage_val[i];
      r.lost  = lost;
      r.last  = (i == CHANNELS - 1);
      pending_chans.push_back(r);
    end
    last_lost = lost;
    return CHANNELS;
  endfunction

  function automatic int decode_item(input logic m, input logic [7:0] b);
    int          made;
    logic [15:0] word;
    logic [3:0]  id;
    logic [10:0] val;
    made = 0;
    if (m) begin
      if (int'(tick_cnt) + 1 > int'(cfg.tick_limit)) begin
        fr_sync = 1'b0;
        fr_pos  = '0;
        fr_prev = rcsfd_pkg::PREV_BYTE_RST;
        fr_bad  = 1'b0;
        if (int'(resync_cnt) + 1 > int'(cfg.lost_limit)) begin
          resync_cnt = '0;
          foreach (stage_val[i]) stage_val[i] = '0;
          made = push_run(1'b1);
        end else begin
          resync_cnt = resync_cnt + 6'd1;
        end
        tick_cnt = '0;
      end else begin
        tick_cnt = tick_cnt + 4'd1;
      end
      return made;
    end
    fr_pos = fr_pos + 5'd1;
    if (!fr_sync) begin
      if (fr_pos == rcsfd_pkg::SYNC_POS) begin
        if (b == rcsfd_pkg::SYNC_NARROW_A || b == rcsfd_pkg::SYNC_NARROW_B ||
            b == rcsfd_pkg::SYNC_NARROW_C) begin
          fr_wide = 1'b0;
          fr_sync = 1'b1;
        end else if (b == rcsfd_pkg::SYNC_WIDE) begin
          fr_wide = 1'b1;
          fr_sync = 1'b1;
        end else begin
          fr_pos = '0;
        end
      end
    end else if (!fr_pos[0]) begin
      word = {fr_prev, b};
      id   = fr_wide ? word[14:11] : word[13:10];
      val  = fr_wide ? word[10:0] : {1'b0, word[9:0]};
      if (id == 4'd0 && val < cfg.throttle_min) fr_bad = 1'b1;
      if (int'(id) < CHANNELS && !fr_bad) stage_val[id] = val;
    end
    if (fr_pos == rcsfd_pkg::FRAME_LEN) begin
      fr_pos     = '0;
      fr_sync    = 1'b0;
      resync_cnt = '0;
      if (!fr_bad) made = push_run(1'b0);
      fr_bad = 1'b0;
    end
    fr_prev = b;
    return made;
  endfunction

  task automatic send_item(input logic m, input logic [7:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    last_made = decode_item(m, b);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_chans.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rcsfd_pkg::REG_TICK_LIMIT:   cfg.tick_limit   = val[3:0];
      rcsfd_pkg::REG_LOST_LIMIT:   cfg.lost_limit   = val[5:0];
      rcsfd_pkg::REG_THROTTLE_MIN: cfg.throttle_min = val[10:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // finish any open frame or sync pair so the next byte starts a frame
  task automatic align_frame();
    logic [7:0] b;
    while (fr_sync || fr_pos != 5'd0) begin
      b = 8'($urandom);
      if (!fr_sync && (b == rcsfd_pkg::SYNC_NARROW_A || b == rcsfd_pkg::SYNC_NARROW_B ||
                       b == rcsfd_pkg::SYNC_NARROW_C || b == rcsfd_pkg::SYNC_WIDE))
        b = 8'h00;
      send_item(1'b0, b);
    end
  endtask

  task automatic send_frame(input bit cut);
    logic [7:0]  sync;
    logic        wide;
    logic [3:0]  id;
    logic [10:0] val;
    logic [15:0] word;
    logic [1:0]  top;
    int          words, bad_at, vmax, thr, hi;
    align_frame();
    case ($urandom_range(0, 3))
      0:       sync = rcsfd_pkg::SYNC_NARROW_A;
      1:       sync = rcsfd_pkg::SYNC_NARROW_B;
      2:       sync = rcsfd_pkg::SYNC_NARROW_C;
      default: sync = rcsfd_pkg::SYNC_WIDE;
    endcase
    wide   = (sync == rcsfd_pkg::SYNC_WIDE);
    vmax   = wide ? 2047 : 1023;
    thr    = int'(cfg.throttle_min);
    words  = cut ? $urandom_range(0, 6) : 7;
    bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : -1;
    send_item(1'b0, 8'($urandom));
    send_item(1'b0, sync);
    for (int w = 0; w < words; w++) begin
      id  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(CHANNELS, 15))
                                         : 4'($urandom_range(0, CHANNELS - 1));
      val = 11'($urandom_range(0, vmax));
      if (w == bad_at && thr > 0) begin
        id  = 4'd0;
        hi  = (thr - 1 > vmax) ? vmax : thr - 1;
        val = 11'($urandom_range(0, hi));
      end else if (id == 4'd0 && int'(val) < thr) begin
        val = (thr > vmax) ? 11'(vmax) : 11'($urandom_range(thr, vmax));
      end
      top  = 2'($urandom);
      word = wide ? {top[0], id, val} : {top, id, val[9:0]};
      send_item(1'b0, word[15:8]);
      send_item(1'b0, word[7:0]);
    end
  endtask

  task automatic run_phase(input int tl, input int ll, input int thr, input bit calm,
                           input bit storm);
    int goal;
    int r;
    wait_idle();
    reg_write(rcsfd_pkg::REG_TICK_LIMIT, 32'(tl));
    reg_write(rcsfd_pkg::REG_LOST_LIMIT, 32'(ll));
    reg_write(rcsfd_pkg::REG_THROTTLE_MIN, 32'(thr));
    quiet = calm;
    goal  = items_sent + PHASE_ITEMS;
    while (items_sent < goal) begin
      r = $urandom_range(0, 19);
      if (r < 13) begin
        send_frame(1'b0);
      end else if (r < 16) begin
        repeat ($urandom_range(1, 4)) send_item(1'b1, 8'($urandom));
      end else if (r < 18) begin
        repeat ($urandom_range(1, 6)) send_item(1'b0, 8'($urandom));
      end else begin
        send_frame(1'b1);
      end
    end
    // drive the tick counter to its top value and the silence count past its limit
    if (storm) repeat (STORM_TICKS) send_item(1'b1, 8'($urandom));
  endtask

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h000, CHK_PRED},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h055, CHK_NONE},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h0FF, CHK_PRED},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h012, CHK_PRED},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h007, CHK_PRED},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h0FF, CHK_NONE},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h058, CHK_PRED},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h000, CHK_NONE},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h07F, CHK_PRED},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h0FF, CHK_NONE},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h02C, CHK_PRED},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h000, CHK_NONE},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h00D, CHK_PRED},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h055, CHK_NONE},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h012, CHK_PRED},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h0AA, CHK_NONE},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h018, CHK_PRED},
    '{ROW_BYTE, rcsfd_pkg::REG_TICK_LIMIT, 11'h001, CHK_PRED},
    '{ROW_CFG,  rcsfd_pkg::REG_TICK_LIMIT, 11'h000, CHK_PRED},
    '{ROW_CFG,  rcsfd_pkg::REG_LOST_LIMIT, 11'h000, CHK_PRED},
    '{ROW_TICK, rcsfd_pkg::REG_TICK_LIMIT, 11'h000, CHK_LOST}
  };

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        reg_write(dir_rows[i].reg_idx, 32'(dir_rows[i].value));
      end else begin
        send_item(dir_rows[i].kind == ROW_TICK, dir_rows[i].value[7:0]);
        if (dir_rows[i].chk == CHK_NONE && last_made != 0) begin
          errors++;
          $error("row %0d: expected no channels, predicted %0d", i, last_made);
        end
        if (dir_rows[i].chk == CHK_LOST && (last_made != CHANNELS || !last_lost)) begin
          errors++;
          $error("row %0d: expected a signal-lost run, predicted %0d", i, last_made);
        end
      end
    end

    run_phase(15, 2, 0, 1'b0, 1'b1);
    run_phase(0, 0, 2047, 1'b0, 1'b0);
    run_phase(2, 3, $urandom_range(0, 1023), 1'b0, 1'b0);
    run_phase(rcsfd_pkg::TICK_LIMIT_RST, rcsfd_pkg::LOST_LIMIT_RST,
              rcsfd_pkg::THROTTLE_MIN_RST, 1'b0, 1'b0);
    run_phase($urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 2047),
              1'b0, 1'b0);
    run_phase(1, 1, 0, 1'b1, 1'b0);

    wait_idle();
    repeat (2 * (CHANNELS + 1)) @(posedge clk_i);
    if (errors == 0 && pending_chans.size() == 0) begin
      $display("rc_satellite_frame_decoder test passed");
    end else begin
      $display("rc_satellite_frame_decoder test failed");
    end
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : chan_check
    chan_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chans.size() == 0) begin
        errors++;
        $error("unexpected transfer: channel_index %0d channel_value %0d",
               channel_index_o, channel_value_o);
      end else begin
        want = pending_chans.pop_front();
        if (channel_index_o !== want.index) begin
          errors++;
          $error("channel_index expected %0d actual %0d", want.index, channel_index_o);
        end
        if (channel_value_o !== want.value) begin
          errors++;
          $error("channel_value expected %0d actual %0d", want.value, channel_value_o);
        end
        if (signal_lost_o !== want.lost) begin
          errors++;
          $error("signal_lost expected %0d actual %0d", want.lost, signal_lost_o);
        end
        if (last_o !== want.last) begin
          errors++;
          $error("last expected %0d actual %0d", want.last, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("rc_satellite_frame_decoder test failed");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
design/rcsfd_pkg.sv
design/rcsfd_cfg.sv
design/rcsfd_ctrl.sv
design/rcsfd_dpath.sv
design/rc_satellite_frame_decoder.sv
design/rcsfd_checker.sv
tb/sv/rc_satellite_frame_decoder_tb.sv
